/* design/wsf_pkg.sv */
// Shared types and constants of the window statistics features block.
package wsf_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 23;
    localparam int TICKS_REG_W = 9;
    localparam int AXES_REG_W  = 4;
    localparam int ENABLE_W    = 5;
    localparam int THR_W       = 23;
    localparam int VALUE_W     = 56;
    localparam int KIND_W      = 3;
    localparam int AXIS_OUT_W  = 3;
    localparam int FRAC_BITS   = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_TICKS       = 2'd0,
        CFG_AXIS_COUNT         = 2'd1,
        CFG_FEATURE_ENABLE     = 2'd2,
        CFG_CROSSING_THRESHOLD = 2'd3
    } wsf_cfg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_RANGE    = 3'd0,
        KIND_MEAN     = 3'd1,
        KIND_ENERGY   = 3'd2,
        KIND_VARIANCE = 3'd3,
        KIND_MIN      = 3'd4,
        KIND_MAX      = 3'd5,
        KIND_CROSS    = 3'd6
    } wsf_kind_t;

    // Feature groups in emission order, one enable bit each.
    localparam logic [2:0] GRP_RANGE_MEAN = 3'd0;
    localparam logic [2:0] GRP_ENERGY     = 3'd1;
    localparam logic [2:0] GRP_VARIANCE   = 3'd2;
    localparam logic [2:0] GRP_MIN_MAX    = 3'd3;
    localparam logic [2:0] GRP_CROSSING   = 3'd4;
    localparam logic [2:0] GRP_DONE       = 3'd5;

    typedef struct packed {
        logic      load;
        logic      acc;
        logic      clear;
        logic      axis_clear;
        logic      axis_inc;
        logic      prep1;
        logic      prep2;
        logic      div_start;
        logic      scan_start;
        logic      latch;
        wsf_kind_t kind;
        logic      last;
    } wsf_cmd_t;

    typedef struct packed {
        logic                win_full;
        logic                div_done;
        logic                scan_done;
        logic                axis_last;
        logic [ENABLE_W-1:0] enable;
    } wsf_status_t;

endpackage

/* design/wsf_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module wsf_div
    import wsf_pkg::*;
#(
    parameter int DVW = 57,
    parameter int DSW = 18
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic           busy,
    output logic           done,
    output logic [DVW-1:0] quotient
);

    localparam int CW = $clog2(DVW + 1);

    logic [DSW-1:0] rem_reg;
    logic [DVW-1:0] quo_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [DSW:0]   trial;
    logic [DSW:0]   diff;
    logic           ge;

    assign trial = {rem_reg, quo_reg[DVW-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(DVW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DSW-1:0] : trial[DSW-1:0];
            quo_reg <= {quo_reg[DVW-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/wsf_dp.sv */
// Datapath: configuration, window store, per-axis accumulators and feature arithmetic.
module wsf_dp
    import wsf_pkg::*;
#(
    parameter int MAX_TICKS   = 256,
    parameter int MAX_AXES    = 8,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  wsf_cmd_t                      cmd,
    output wsf_status_t                   stat,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic [VALUE_W-1:0]            out_value,
    output logic [KIND_W-1:0]             out_kind,
    output logic [AXIS_OUT_W-1:0]         out_axis,
    output logic                          out_last
);

    localparam int TW    = $clog2(MAX_TICKS + 1);
    localparam int AXW   = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam int ACW   = $clog2(MAX_AXES + 1);
    localparam int DEPTH = MAX_TICKS * MAX_AXES;
    localparam int ADW   = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int SUMW  = SAMPLE_BITS + $clog2(MAX_TICKS);
    localparam int SQW   = 2 * SAMPLE_BITS + $clog2(MAX_TICKS);
    localparam int SPW   = SQW + TW;
    localparam int DVW   = SPW + FRAC_BITS;
    localparam int DSW   = 2 * TW;
    localparam int XW    = (DVW + 2 > VALUE_W + 1) ? DVW + 2 : VALUE_W + 1;
    localparam int CMA   = SAMPLE_BITS + TW + FRAC_BITS + 1;
    localparam int CMB   = THR_W + TW;
    localparam int CMPW  = ((CMA > CMB) ? CMA : CMB) + 2;

    localparam logic signed [SAMPLE_BITS-1:0] S_TOP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_BOT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Configuration registers.
    logic [TICKS_REG_W-1:0] ticks_cfg_reg;
    logic [AXES_REG_W-1:0]  axes_cfg_reg;
    logic [ENABLE_W-1:0]    enable_reg;
    logic [THR_W-1:0]       thr_reg;
    logic [TW-1:0]          ticks_used;
    logic [ACW-1:0]         axes_used;
    logic [TW+ACW-1:0]      total_prod;
    logic [CNTW-1:0]        total;
    logic                   geom_wr;
    logic                   clr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_cfg_reg <= TICKS_REG_W'(128);
            axes_cfg_reg  <= AXES_REG_W'(3);
            enable_reg    <= ENABLE_W'(31);
            thr_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_TICKS:       ticks_cfg_reg <= cfg_data[TICKS_REG_W-1:0];
                CFG_AXIS_COUNT:         axes_cfg_reg  <= cfg_data[AXES_REG_W-1:0];
                CFG_FEATURE_ENABLE:     enable_reg    <= cfg_data[ENABLE_W-1:0];
                CFG_CROSSING_THRESHOLD: thr_reg       <= cfg_data[THR_W-1:0];
                default:                thr_reg       <= thr_reg;
            endcase
        end
    end

    always_comb
    begin
        if (ticks_cfg_reg < TICKS_REG_W'(2))
            ticks_used = TW'(2);
        else if (32'(ticks_cfg_reg) > MAX_TICKS)
            ticks_used = TW'(MAX_TICKS);
        else
            ticks_used = TW'(ticks_cfg_reg);

        if (axes_cfg_reg == '0)
            axes_used = ACW'(1);
        else if (32'(axes_cfg_reg) > MAX_AXES)
            axes_used = ACW'(MAX_AXES);
        else
            axes_used = ACW'(axes_cfg_reg);
    end

    assign total_prod = (TW+ACW)'(ticks_used) * (TW+ACW)'(axes_used);
    assign total      = CNTW'(total_prod);
    assign geom_wr    = cfg_we && (cfg_index == CFG_WINDOW_TICKS ||
                                   cfg_index == CFG_AXIS_COUNT);
    assign clr        = cmd.clear || geom_wr;

    // Load stage and per-axis accumulators.
    logic [CNTW-1:0]               cnt_reg;
    logic [AXW-1:0]                lax_reg;
    logic [AXW-1:0]                sax_reg;
    logic [AXW-1:0]                eax_reg;
    logic signed [SAMPLE_BITS-1:0] smp_reg;
    logic [2*SAMPLE_BITS-1:0]      sqp_reg;
    logic signed [SUMW-1:0]        sum_reg [MAX_AXES];
    logic [SQW-1:0]                sq_reg  [MAX_AXES];
    logic signed [SAMPLE_BITS-1:0] min_reg [MAX_AXES];
    logic signed [SAMPLE_BITS-1:0] max_reg [MAX_AXES];
    logic [AXW-1:0]                ax_sel;
    logic signed [SUMW-1:0]        s1;
    logic [SQW-1:0]                s2;
    logic signed [SAMPLE_BITS-1:0] mn;
    logic signed [SAMPLE_BITS-1:0] mx;
    logic [SUMW-1:0]               mag;
    logic signed [2*SAMPLE_BITS-1:0] sq_full;

    assign ax_sel  = cmd.acc ? sax_reg : eax_reg;
    assign s1      = sum_reg[ax_sel];
    assign s2      = sq_reg[ax_sel];
    assign mn      = min_reg[ax_sel];
    assign mx      = max_reg[ax_sel];
    assign mag     = s1[SUMW-1] ? SUMW'(-s1) : SUMW'(s1);
    assign sq_full = in_sample * in_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            lax_reg <= '0;
            eax_reg <= '0;
            for (int j = 0; j < MAX_AXES; j++)
            begin
                sum_reg[j] <= '0;
                sq_reg[j]  <= '0;
                min_reg[j] <= S_TOP;
                max_reg[j] <= S_BOT;
            end
        end
        else
        begin
            if (clr)
            begin
                cnt_reg <= '0;
                lax_reg <= '0;
                for (int j = 0; j < MAX_AXES; j++)
                begin
                    sum_reg[j] <= '0;
                    sq_reg[j]  <= '0;
                    min_reg[j] <= S_TOP;
                    max_reg[j] <= S_BOT;
                end
            end
            else
            begin
                if (cmd.load)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (int'(lax_reg) + 1 == int'(axes_used))
                        lax_reg <= '0;
                    else
                        lax_reg <= lax_reg + 1'b1;
                end
                if (cmd.acc)
                begin
                    sum_reg[sax_reg] <= s1 + SUMW'(smp_reg);
                    sq_reg[sax_reg]  <= s2 + SQW'(sqp_reg);
                    if (smp_reg < mn)
                        min_reg[sax_reg] <= smp_reg;
                    if (smp_reg > mx)
                        max_reg[sax_reg] <= smp_reg;
                end
            end

            if (cmd.axis_clear)
                eax_reg <= '0;
            else if (cmd.axis_inc)
                eax_reg <= eax_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            smp_reg <= in_sample;
            sqp_reg <= (2*SAMPLE_BITS)'(sq_full);
            sax_reg <= lax_reg;
        end
    end

    // Window store: written while loading, read while scanning for crossings.
    logic signed [SAMPLE_BITS-1:0] store [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic [ADW-1:0]                addr_reg;
    logic                          rd_en;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            store[cnt_reg[ADW-1:0]] <= in_sample;
        if (rd_en)
            rd_data_reg <= store[addr_reg];
    end

    // Spread and divider operands.
    logic [SPW-1:0]    ns2_reg;
    logic [2*SUMW-1:0] s1sq_reg;
    logic [SPW-1:0]    spread_reg;
    logic              neg_reg;
    logic [DVW-1:0]    dividend;
    logic [DSW-1:0]    divisor;
    logic [DVW-1:0]    quotient;
    logic              div_busy;
    logic              div_done;

    always_ff @(posedge clk)
    begin
        if (cmd.prep1)
        begin
            ns2_reg  <= SPW'(ticks_used * s2);
            s1sq_reg <= (2*SUMW)'(mag) * (2*SUMW)'(mag);
        end
        if (cmd.prep2)
            spread_reg <= ns2_reg - SPW'(s1sq_reg);
        if (cmd.div_start)
            neg_reg <= (cmd.kind == KIND_MEAN) && s1[SUMW-1];
    end

    always_comb
    begin
        if (cmd.kind == KIND_MEAN)
            dividend = DVW'({mag, {FRAC_BITS{1'b0}}});
        else
            dividend = {spread_reg, {FRAC_BITS{1'b0}}};
        if (cmd.kind == KIND_VARIANCE)
            divisor = DSW'(ticks_used) * DSW'(ticks_used);
        else
            divisor = DSW'(ticks_used);
    end

    wsf_div #(
        .DVW (DVW),
        .DSW (DSW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // Crossing scan over one axis column of the store.
    logic signed [CMPW-1:0] band_reg;
    logic signed [CMPW-1:0] lo_reg;
    logic signed [CMPW-1:0] hi_reg;
    logic signed [CMPW-1:0] s1_scaled;
    logic signed [CMPW-1:0] xs;
    logic signed [CMPW-1:0] ns;
    logic signed [CMPW-1:0] x;
    logic                   sc_busy_reg;
    logic                   rv_reg;
    logic                   scan_done_reg;
    logic [TW-1:0]          iss_reg;
    logic [TW-1:0]          rcv_reg;
    logic [TW-1:0]          xcnt_reg;
    logic                   pblo_reg;
    logic                   pahi_reg;
    logic                   blo;
    logic                   alo;
    logic                   ahi;
    logic                   bhi;

    assign s1_scaled = CMPW'(s1) <<< FRAC_BITS;
    assign xs        = CMPW'(rd_data_reg);
    assign ns        = CMPW'({1'b0, ticks_used});
    assign x         = (xs * ns) <<< FRAC_BITS;
    assign blo       = x < lo_reg;
    assign alo       = x > lo_reg;
    assign ahi       = x > hi_reg;
    assign bhi       = x < hi_reg;
    assign rd_en     = sc_busy_reg && (iss_reg < ticks_used);

    always_ff @(posedge clk)
    begin
        band_reg <= CMPW'(thr_reg * ticks_used);
        if (cmd.scan_start)
        begin
            lo_reg <= s1_scaled - band_reg;
            hi_reg <= s1_scaled + band_reg;
        end
        if (cmd.scan_start)
            addr_reg <= ADW'(eax_reg);
        else if (rd_en)
            addr_reg <= addr_reg + ADW'(axes_used);
        if (rv_reg)
        begin
            pblo_reg <= blo;
            pahi_reg <= ahi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_busy_reg   <= 1'b0;
            rv_reg        <= 1'b0;
            scan_done_reg <= 1'b0;
            iss_reg       <= '0;
            rcv_reg       <= '0;
            xcnt_reg      <= '0;
        end
        else if (cmd.scan_start)
        begin
            sc_busy_reg   <= 1'b1;
            rv_reg        <= 1'b0;
            scan_done_reg <= 1'b0;
            iss_reg       <= '0;
            rcv_reg       <= '0;
            xcnt_reg      <= '0;
        end
        else
        begin
            scan_done_reg <= 1'b0;
            rv_reg        <= rd_en;
            if (rd_en)
                iss_reg <= iss_reg + 1'b1;
            if (rv_reg && sc_busy_reg)
            begin
                rcv_reg <= rcv_reg + 1'b1;
                if (rcv_reg != '0 && ((pblo_reg && alo) || (pahi_reg && bhi)))
                    xcnt_reg <= xcnt_reg + 1'b1;
                if (rcv_reg == ticks_used - 1'b1)
                begin
                    sc_busy_reg   <= 1'b0;
                    scan_done_reg <= 1'b1;
                end
            end
        end
    end

    // Result formation with saturation to the output range.
    logic signed [XW-1:0]      val;
    logic signed [XW-1:0]      qx;
    logic [VALUE_W-1:0]        val_sat;
    logic [XW-VALUE_W:0]       top_bits;
    logic [VALUE_W-1:0]        value_reg;
    logic [KIND_W-1:0]         kind_reg;
    logic [AXIS_OUT_W-1:0]     axis_reg;
    logic                      last_reg;

    assign qx = neg_reg ? -XW'(quotient) : XW'(quotient);

    always_comb
    begin
        case (cmd.kind)
            KIND_RANGE:    val = (XW'(mx) - XW'(mn)) <<< FRAC_BITS;
            KIND_MEAN,
            KIND_ENERGY,
            KIND_VARIANCE: val = qx;
            KIND_MIN:      val = XW'(mn) <<< FRAC_BITS;
            KIND_MAX:      val = XW'(mx) <<< FRAC_BITS;
            KIND_CROSS:    val = XW'(xcnt_reg) <<< FRAC_BITS;
            default:       val = '0;
        endcase
        top_bits = val[XW-1:VALUE_W-1];
        if ((&top_bits) || !(|top_bits))
            val_sat = val[VALUE_W-1:0];
        else if (val[XW-1])
            val_sat = {1'b1, {(VALUE_W-1){1'b0}}};
        else
            val_sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            value_reg <= val_sat;
            kind_reg  <= cmd.kind;
            axis_reg  <= AXIS_OUT_W'(eax_reg);
            last_reg  <= cmd.last;
        end
    end

    assign out_value      = value_reg;
    assign out_kind       = kind_reg;
    assign out_axis       = axis_reg;
    assign out_last       = last_reg;

    assign stat.win_full  = (cnt_reg == total);
    assign stat.div_done  = div_done && !div_busy;
    assign stat.scan_done = scan_done_reg;
    assign stat.axis_last = (int'(eax_reg) + 1 == int'(axes_used));
    assign stat.enable    = enable_reg;

endmodule

/* design/wsf_ctrl.sv */
// Controller: sequences sample loading, the feature pass and result beats.
module wsf_ctrl
    import wsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  wsf_status_t stat,
    output wsf_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_SEL,
        ST_PREP2,
        ST_DSTART,
        ST_DIV,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [2:0]          grp_reg;
    logic [2:0]          grp_next;
    logic                half_reg;
    logic                half_next;
    logic                tready_reg;
    logic                tready_next;
    logic                tvalid_reg;
    logic                tvalid_next;
    logic                pair;
    logic [ENABLE_W-1:0] en_here;
    logic [ENABLE_W-1:0] en_above;
    logic                grp_en;
    wsf_kind_t           kind;

    assign pair     = (grp_reg == GRP_RANGE_MEAN) || (grp_reg == GRP_MIN_MAX);
    assign en_here  = stat.enable >> grp_reg;
    assign en_above = stat.enable >> (grp_reg + 3'd1);
    assign grp_en   = en_here[0];

    always_comb
    begin
        case (grp_reg)
            GRP_RANGE_MEAN: kind = half_reg ? KIND_MEAN : KIND_RANGE;
            GRP_ENERGY:     kind = KIND_ENERGY;
            GRP_VARIANCE:   kind = KIND_VARIANCE;
            GRP_MIN_MAX:    kind = half_reg ? KIND_MAX : KIND_MIN;
            GRP_CROSSING:   kind = KIND_CROSS;
            default:        kind = KIND_RANGE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.kind     = kind;
        cmd.last     = (!pair || half_reg) && stat.axis_last && (en_above == '0);
        state_next   = state_reg;
        grp_next     = grp_reg;
        half_next    = half_reg;
        tready_next  = tready_reg;
        tvalid_next  = tvalid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && tready_reg)
                begin
                    cmd.load    = 1'b1;
                    tready_next = 1'b0;
                    state_next  = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (stat.win_full)
                begin
                    grp_next       = GRP_RANGE_MEAN;
                    half_next      = 1'b0;
                    cmd.axis_clear = 1'b1;
                    state_next     = ST_SEL;
                end
                else
                begin
                    tready_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_SEL:
            begin
                if (grp_reg == GRP_DONE)
                begin
                    cmd.clear   = 1'b1;
                    tready_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (!grp_en)
                begin
                    grp_next       = grp_reg + 3'd1;
                    half_next      = 1'b0;
                    cmd.axis_clear = 1'b1;
                end
                else
                begin
                    case (kind)
                        KIND_MEAN:
                            state_next = ST_DSTART;
                        KIND_ENERGY,
                        KIND_VARIANCE:
                        begin
                            cmd.prep1  = 1'b1;
                            state_next = ST_PREP2;
                        end
                        KIND_CROSS:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        default:
                        begin
                            cmd.latch   = 1'b1;
                            tvalid_next = 1'b1;
                            state_next  = ST_OUT;
                        end
                    endcase
                end
            end
            ST_PREP2:
            begin
                cmd.prep2  = 1'b1;
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.latch   = 1'b1;
                    tvalid_next = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.latch   = 1'b1;
                    tvalid_next = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    tvalid_next = 1'b0;
                    state_next  = ST_SEL;
                    if (pair && !half_reg)
                    begin
                        half_next = 1'b1;
                    end
                    else
                    begin
                        half_next = 1'b0;
                        if (stat.axis_last)
                        begin
                            cmd.axis_clear = 1'b1;
                            grp_next       = grp_reg + 3'd1;
                        end
                        else
                        begin
                            cmd.axis_inc = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            grp_reg    <= GRP_RANGE_MEAN;
            half_reg   <= 1'b0;
            tready_reg <= 1'b1;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            grp_reg    <= grp_next;
            half_reg   <= half_next;
            tready_reg <= tready_next;
            tvalid_reg <= tvalid_next;
        end
    end

    assign s_tready = tready_reg;
    assign m_tvalid = tvalid_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(tready_reg && tvalid_reg))
        else $error("input ready while a result beat is pending");
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide wait");
    a_scan_state: assert property (@(posedge clk) disable iff (!rst_n)
        stat.scan_done |-> state_reg == ST_SCAN)
        else $error("scan finished outside the scan wait");
    a_latch_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |=> (tvalid_reg && state_reg == ST_OUT))
        else $error("latched result not presented");
`endif

endmodule

/* design/window_statistics_features_core.sv */
// Top level of the windowed time-series statistics core.
//
// The core collects interleaved multi-axis samples (all axes of tick 0, then
// all axes of tick 1, and so on) into a window store of MAX_TICKS*MAX_AXES
// entries while it keeps per-axis sums, sums of squares, minima and maxima.
// Each sample beat is accepted and stored in the idle state, and the
// accumulators of its axis are updated in the accumulate state; input stays
// blocked until that update is done. When the window holds window_ticks
// times axis_count samples, the core stops taking input and emits, for each
// enabled group in order (range and mean, energy, variance, minimum and
// maximum, crossings) and within a group for each axis in order, one result
// beat per feature. Range, minimum and maximum are latched from the
// accumulators; mean, energy and variance each go through a shared restoring
// divider that produces one quotient bit per cycle, with a dividend of
// 2*SAMPLE_BITS + log2(MAX_TICKS) + log2(MAX_TICKS+1) + 8 bits; a crossing
// count reads the axis column of the store one entry per cycle. tlast marks
// the final beat of a window; the core then starts an empty window. Writing
// window_ticks or axis_count discards the partial window; the other
// registers are read at the window end. The store needs no clearing pass,
// since only entries of the current window are read. Out-of-range geometry
// values are clamped, and every feature value saturates to the signed 56-bit
// range.
module window_statistics_features_core
    import wsf_pkg::*;
#(
    parameter int MAX_TICKS   = 256,
    parameter int MAX_AXES    = 8,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Input sample beats.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // sample
    // Result beats.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [VALUE_W-1:0]              m_axis_tdata,  // feature_value
    output logic [KIND_W+AXIS_OUT_W-1:0]    m_axis_tuser,  // feature_kind, axis_index
    output logic                            m_axis_tlast,  // last_feature
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data
);

    wsf_cmd_t              cmd;
    wsf_status_t           stat;
    logic [KIND_W-1:0]     out_kind;
    logic [AXIS_OUT_W-1:0] out_axis;

    // The controller owns both handshakes; the datapath holds all payload.
    wsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wsf_dp #(
        .MAX_TICKS   (MAX_TICKS),
        .MAX_AXES    (MAX_AXES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .out_value (m_axis_tdata),
        .out_kind  (out_kind),
        .out_axis  (out_axis),
        .out_last  (m_axis_tlast)
    );

    // Kind in the low bits, axis above it.
    assign m_axis_tuser = {out_axis, out_kind};

endmodule

/* verif/window_statistics_features_core_tb.sv */
// Self-checking testbench for the window statistics features core.
`timescale 1ns / 1ps

module window_statistics_features_core_tb;
    import wsf_pkg::*;

    localparam int MAX_TICKS = 256;
    localparam int MAX_AXES  = 8;
    localparam int SAMPLE_W  = 16;
    localparam int STORE_SZ  = MAX_TICKS * MAX_AXES;
    localparam longint VAL_HI = (longint'(1) << 55) - 1;
    localparam longint VAL_LO = -VAL_HI - 1;

    typedef struct {
        logic [VALUE_W-1:0] value;
        wsf_kind_t          kind;
        logic [2:0]         axis;
        logic               last;
    } feature_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [VALUE_W-1:0]   m_axis_tdata;
    logic [5:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    window_statistics_features_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Shadow copy of the block's registers and window state.
    logic [8:0]  ticks_reg;
    logic [3:0]  axes_reg;
    logic [4:0]  enable_reg;
    logic [22:0] thresh_reg;
    shortint     win_samples [STORE_SZ];
    int          win_fill;
    longint      col_sum  [MAX_AXES];
    longint      col_sumsq[MAX_AXES];
    int          col_min  [MAX_AXES];
    int          col_max  [MAX_AXES];

    feature_t feature_q[$];
    int       mismatches;
    bit       calm;        // when set, neither side inserts gaps
    int       sent_count;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic int used_ticks();
        if (ticks_reg < 2)
            return 2;
        if (ticks_reg > MAX_TICKS)
            return MAX_TICKS;
        return ticks_reg;
    endfunction

    function automatic int used_axes();
        if (axes_reg < 1)
            return 1;
        if (axes_reg > MAX_AXES)
            return MAX_AXES;
        return axes_reg;
    endfunction

    function automatic void restart_window();
        win_fill = 0;
        for (int j = 0; j < MAX_AXES; j++)
        begin
            col_sum[j]   = 0;
            col_sumsq[j] = 0;
            col_min[j]   = 32767;
            col_max[j]   = -32768;
        end
    endfunction

    function automatic void push_feature(longint v, wsf_kind_t kind, int axis);
        feature_t f;
        if (v > VAL_HI)
            v = VAL_HI;
        if (v < VAL_LO)
            v = VAL_LO;
        f.value = v[VALUE_W-1:0];
        f.kind  = kind;
        f.axis  = axis[2:0];
        f.last  = 1'b0;
        feature_q.push_back(f);
    endfunction

    // Adds one sample to the shadow window and, when the window fills up,
    // queues the features that the block must emit.
    function automatic void predict_window_features(logic [15:0] raw);
        int     nt;
        int     na;
        int     axis;
        int     before_len;
        int     crossings;
        longint v;
        longint n;
        longint spread;
        longint lo_lvl;
        longint hi_lvl;
        longint x0;
        longint x1;
        nt = used_ticks();
        na = used_axes();
        v  = longint'($signed(raw));
        axis = win_fill % na;
        win_samples[win_fill] = shortint'(v);
        col_sum[axis]   += v;
        col_sumsq[axis] += v * v;
        if (v < col_min[axis])
            col_min[axis] = int'(v);
        if (v > col_max[axis])
            col_max[axis] = int'(v);
        win_fill++;
        if (win_fill < nt * na)
            return;
        n = nt;
        before_len = feature_q.size();
        if (enable_reg[GRP_RANGE_MEAN])
            for (int j = 0; j < na; j++)
            begin
                push_feature((longint'(col_max[j]) - col_min[j]) * 256, KIND_RANGE, j);
                push_feature(col_sum[j] * 256 / n, KIND_MEAN, j);
            end
        if (enable_reg[GRP_ENERGY])
            for (int j = 0; j < na; j++)
            begin
                spread = n * col_sumsq[j] - col_sum[j] * col_sum[j];
                push_feature(spread * 256 / n, KIND_ENERGY, j);
            end
        if (enable_reg[GRP_VARIANCE])
            for (int j = 0; j < na; j++)
            begin
                spread = n * col_sumsq[j] - col_sum[j] * col_sum[j];
                push_feature(spread * 256 / (n * n), KIND_VARIANCE, j);
            end
        if (enable_reg[GRP_MIN_MAX])
            for (int j = 0; j < na; j++)
            begin
                push_feature(longint'(col_min[j]) * 256, KIND_MIN, j);
                push_feature(longint'(col_max[j]) * 256, KIND_MAX, j);
            end
        if (enable_reg[GRP_CROSSING])
            for (int j = 0; j < na; j++)
            begin
                // Everything is scaled by 256*N so the exact mean stays integral.
                lo_lvl = col_sum[j] * 256 - longint'(thresh_reg) * n;
                hi_lvl = col_sum[j] * 256 + longint'(thresh_reg) * n;
                crossings = 0;
                for (int i = 0; i + 1 < nt; i++)
                begin
                    x0 = longint'(win_samples[i * na + j]) * 256 * n;
                    x1 = longint'(win_samples[(i + 1) * na + j]) * 256 * n;
                    if ((x0 < lo_lvl && x1 > lo_lvl) || (x0 > hi_lvl && x1 < hi_lvl))
                        crossings++;
                end
                push_feature(longint'(crossings) * 256, KIND_CROSS, j);
            end
        if (feature_q.size() > before_len)
            feature_q[feature_q.size() - 1].last = 1'b1;
        restart_window();
    endfunction

    // Register write; called only while the block is idle.
    task automatic write_reg(wsf_cfg_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_WINDOW_TICKS:
            begin
                ticks_reg = val[8:0];
                restart_window();
            end
            CFG_AXIS_COUNT:
            begin
                axes_reg = val[3:0];
                restart_window();
            end
            CFG_FEATURE_ENABLE:     enable_reg = val[4:0];
            default:                thresh_reg = val[22:0];
        endcase
    endtask

    task automatic setup(int t, int a, int en, int thr);
        write_reg(CFG_WINDOW_TICKS, CFG_DATA_W'(t));
        write_reg(CFG_AXIS_COUNT, CFG_DATA_W'(a));
        write_reg(CFG_FEATURE_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_CROSSING_THRESHOLD, CFG_DATA_W'(thr));
    endtask

    // Drives one sample beat and waits until the block takes it.
    task automatic send_sample(logic [15:0] s);
        int g;
        @(negedge clk);
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_window_features(s);
        sent_count++;
    endtask

    // Waits until every expected feature has arrived, then lets the block
    // finish any trailing work before the next register write.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (feature_q.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h7FFF;
        if (r == 1)
            return 16'h8000;
        if (r < 6)
            return 16'($urandom_range(0, 40)) - 16'd20;
        return 16'($urandom);
    endfunction

    task automatic send_window(bit noisy);
        for (int i = 0; i < used_ticks() * used_axes(); i++)
            send_sample(noisy ? rand_sample() : 16'($urandom_range(0, 8)) - 16'd4);
    endtask

    // Receiver stall pattern.
    always @(negedge clk)
        m_axis_tready <= (gap_len() == 0);

    // Compares every result beat with the oldest expectation.
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (feature_q.size() == 0)
            begin
                $display("%0t: unexpected beat value=%0d kind=%0d axis=%0d", $time,
                         $signed(m_axis_tdata), m_axis_tuser[2:0], m_axis_tuser[5:3]);
                mismatches++;
            end
            else
            begin
                feature_t f;
                f = feature_q.pop_front();
                if (m_axis_tdata !== f.value)
                begin
                    $display("%0t: value expected %0d actual %0d", $time,
                             $signed(f.value), $signed(m_axis_tdata));
                    mismatches++;
                end
                if (m_axis_tuser[2:0] !== f.kind)
                begin
                    $display("%0t: kind expected %0d actual %0d", $time,
                             f.kind, m_axis_tuser[2:0]);
                    mismatches++;
                end
                if (m_axis_tuser[5:3] !== f.axis)
                begin
                    $display("%0t: axis expected %0d actual %0d", $time,
                             f.axis, m_axis_tuser[5:3]);
                    mismatches++;
                end
                if (m_axis_tlast !== f.last)
                begin
                    $display("%0t: tlast expected %0b actual %0b", $time,
                             f.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end

    // Full-scale samples in both orders, with zero and then the widest crossing band.
    task automatic test_extremes();
        setup(2, 1, 31, 0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        drain();
        setup(3, 2, 31, 23'h7FFFFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        drain();
    endtask

    // Out-of-range geometry is clamped to the nearest legal value.
    task automatic test_geometry_clamp();
        setup(0, 0, 31, 0);
        send_sample(16'd5);
        send_sample(16'hFFFB);
        drain();
        setup(1, 12, 31, 256);
        send_window(1);
        drain();
        // Longest window, one axis.
        setup(300, 1, 31, 128);
        send_window(1);
        drain();
    endtask

    // A geometry write drops a partly filled window.
    task automatic test_partial_discard();
        setup(3, 2, 31, 0);
        send_sample(16'd100);
        send_sample(16'd200);
        send_sample(16'd300);
        drain();
        write_reg(CFG_WINDOW_TICKS, 3);
        send_window(0);
        drain();
        send_sample(16'd7);
        drain();
        write_reg(CFG_AXIS_COUNT, 2);
        send_window(0);
        drain();
    endtask

    // Each group on its own, then none at all.
    task automatic test_enable_groups();
        for (int g = 0; g < ENABLE_W; g++)
        begin
            write_reg(CFG_FEATURE_ENABLE, CFG_DATA_W'(1 << g));
            send_window(0);
            drain();
        end
        write_reg(CFG_FEATURE_ENABLE, 0);
        send_window(0);
        drain();
    endtask

    // Random windows, mostly small, with random geometry and settings.
    task automatic test_random_windows();
        int done;
        int thr;
        done = sent_count;
        while (sent_count - done < 40)
        begin
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0: thr = 0;
                1: thr = $urandom_range(0, 2048);
                2: thr = $urandom & 23'h7FFFFF;
                default: thr = 23'h7FFFFF;
            endcase
            setup($urandom_range(0, 3) == 0 ? $urandom_range(0, 511) % 24
                                            : $urandom_range(2, 10),
                  $urandom_range(0, 4) == 0 ? $urandom_range(0, 15)
                                            : $urandom_range(1, 8),
                  $urandom_range(0, 5) == 0 ? $urandom_range(0, 31) : 31,
                  thr);
            send_window($urandom_range(0, 3) != 0);
            drain();
        end
        calm = 1'b0;
        // Axis count above the supported range on a short window.
        setup(9'h1FF, 4'hF, 31, 23'h7FFFFF);
        write_reg(CFG_WINDOW_TICKS, 9'h002);
        write_reg(CFG_AXIS_COUNT, 4'h9);
        send_window(1);
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_WINDOW_TICKS;
        cfg_data      = '0;
        ticks_reg     = 9'd128;
        axes_reg      = 4'd3;
        enable_reg    = 5'd31;
        thresh_reg    = '0;
        mismatches    = 0;
        sent_count    = 0;
        calm          = 1'b0;
        for (int i = 0; i < STORE_SZ; i++)
            win_samples[i] = 0;
        restart_window();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_geometry_clamp();
        test_partial_discard();
        test_enable_groups();
        test_random_windows();
        if (mismatches == 0)
            $display("[window_statistics_features_core] OK");
        else
            $display("[window_statistics_features_core] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[window_statistics_features_core] ERROR");
        $finish;
    end

endmodule

/* window_statistics_features_core.f */
design/wsf_pkg.sv
design/wsf_div.sv
design/wsf_dp.sv
design/wsf_ctrl.sv
design/window_statistics_features_core.sv
verif/window_statistics_features_core_tb.sv
